### sv/rpip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_pkg
// Types and constants shared by the radix prefix integer parser.
// ----------------------------------------------------------------------------
package rpip_pkg;

  localparam int CODE_W  = 8;
  localparam int VALUE_W = 32;
  localparam int RADIX_W = 6;   // a live radix is 2..36
  localparam int DIGIT_W = 9;   // signed mapped byte -16..207, or digit -28..168

  localparam logic [CODE_W-1:0]  CASE_MASK     = 8'hDF;
  localparam logic [CODE_W-1:0]  CODE_END      = 8'h00;
  localparam logic signed [DIGIT_W-1:0] MAP_OFFSET   = 9'sd16;
  localparam logic signed [DIGIT_W-1:0] X_MINUS      = -9'sd3;
  localparam logic signed [DIGIT_W-1:0] X_PREFIX     = 9'sd72;
  localparam logic signed [DIGIT_W-1:0] X_LETTER_MAX = 9'sd10;
  localparam logic signed [DIGIT_W-1:0] LETTER_SHIFT = 9'sd39;

  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_ZERO    = 6'd16;
  localparam logic [VALUE_W-1:0] RADIX_MIN     = 32'd2;
  localparam logic [VALUE_W-1:0] RADIX_MAX     = 32'd36;
  localparam logic [VALUE_W-1:0] VALUE_ERROR   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      error;
  } rpip_result_t;

endpackage

### sv/rpip_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_in_reg
// Input register: holds one byte until the parser core consumes it.
// ----------------------------------------------------------------------------
module rpip_in_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [rpip_pkg::CODE_W-1:0]   in_char_code,
  output logic                          in_stall,
  input  logic                          take,
  output logic                          hold_valid,
  output logic [rpip_pkg::CODE_W-1:0]   hold_code
);

  logic                        valid_r, valid_nxt;
  logic [rpip_pkg::CODE_W-1:0] code_r, code_nxt;
  logic                        accept;

  // a held byte that the core cannot take blocks the input
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    code_nxt  = code_r;
    if (accept) begin
      valid_nxt = 1'b1;
      code_nxt  = in_char_code;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign hold_valid = valid_r;
  assign hold_code  = code_r;

endmodule

### sv/rpip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_core
// Parser state and the per-byte update: sign, radix prefix, digit multiply-add.
// ----------------------------------------------------------------------------
module rpip_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [rpip_pkg::CODE_W-1:0]   code,
  output logic                          is_end,
  output rpip_pkg::rpip_result_t        result
);

  localparam int PROD_W = rpip_pkg::VALUE_W + rpip_pkg::RADIX_W;

  logic [rpip_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [rpip_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic                         neg_r, neg_nxt;
  logic                         err_r, err_nxt;

  logic signed [rpip_pkg::DIGIT_W-1:0] x;
  logic signed [rpip_pkg::DIGIT_W-1:0] digit;
  logic signed [rpip_pkg::DIGIT_W-1:0] radix_s;
  logic        [PROD_W-1:0]            prod;
  logic        [rpip_pkg::VALUE_W-1:0] mac;
  logic        [rpip_pkg::VALUE_W-1:0] new_radix;
  logic                                is_minus, is_prefix, bad_digit, bad_radix;

  assign is_end = (code == rpip_pkg::CODE_END);

  always_comb begin
    x = $signed({1'b0, code & rpip_pkg::CASE_MASK}) - rpip_pkg::MAP_OFFSET;
    is_minus  = (x == rpip_pkg::X_MINUS);
    is_prefix = (x == rpip_pkg::X_PREFIX) && (radix_r == rpip_pkg::RADIX_DEFAULT);
    digit     = (x > rpip_pkg::X_LETTER_MAX) ? (x - rpip_pkg::LETTER_SHIFT) : x;
    radix_s   = $signed({{(rpip_pkg::DIGIT_W-rpip_pkg::RADIX_W){1'b0}}, radix_r});
    bad_digit = (digit >= radix_s);
    prod      = {{rpip_pkg::RADIX_W{1'b0}}, acc_r}
              * {{(PROD_W-rpip_pkg::RADIX_W){1'b0}}, radix_r};
    // negative digits add sign-extended
    mac       = prod[rpip_pkg::VALUE_W-1:0]
              + {{(rpip_pkg::VALUE_W-rpip_pkg::DIGIT_W){digit[rpip_pkg::DIGIT_W-1]}}, digit};
    new_radix = (acc_r == '0) ? {{(rpip_pkg::VALUE_W-rpip_pkg::RADIX_W){1'b0}},
                                 rpip_pkg::RADIX_ZERO} : acc_r;
    bad_radix = (new_radix < rpip_pkg::RADIX_MIN) || (new_radix > rpip_pkg::RADIX_MAX);
  end

  always_comb begin
    result.error = err_r;
    if (err_r) begin
      result.value = rpip_pkg::VALUE_ERROR;
    end else if (neg_r) begin
      result.value = $signed('0 - acc_r);
    end else begin
      result.value = $signed(acc_r);
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    if (step) begin
      if (is_end) begin
        acc_nxt   = '0;
        radix_nxt = rpip_pkg::RADIX_DEFAULT;
        neg_nxt   = 1'b0;
        err_nxt   = 1'b0;
      end else if (!err_r) begin
        if (is_minus) begin
          neg_nxt = !neg_r;
        end else if (is_prefix) begin
          acc_nxt   = '0;
          radix_nxt = new_radix[rpip_pkg::RADIX_W-1:0];
          err_nxt   = bad_radix;
        end else if (bad_digit) begin
          err_nxt = 1'b1;
        end else begin
          acc_nxt = mac;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      radix_r <= rpip_pkg::RADIX_DEFAULT;
      neg_r   <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      radix_r <= radix_nxt;
      neg_r   <= neg_nxt;
      err_r   <= err_nxt;
    end
  end

  // state returns to reset after a terminator
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_end) |=> (acc_r == '0 && radix_r == rpip_pkg::RADIX_DEFAULT
                          && !neg_r && !err_r))
    else $error("parser state not cleared after terminator");

  // without an error the radix stays usable
  a_radix_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !err_r |-> (radix_r >= 6'd2 && radix_r <= 6'd36))
    else $error("illegal radix without error");

  // once in error, only a terminator leaves it
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !(step && is_end)) |=> err_r)
    else $error("error flag dropped before terminator");

  // an ignored byte leaves the accumulator alone
  a_err_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && !(step && is_end)) |=> $stable(acc_r))
    else $error("accumulator changed while in error");

endmodule

### sv/rpip_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpip_out_reg
// Result register: holds one parsed result until the consumer takes it.
// ----------------------------------------------------------------------------
module rpip_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  rpip_pkg::rpip_result_t              result,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rpip_pkg::VALUE_W-1:0] out_parsed_value,
  output logic                                out_parse_error
);

  logic                   valid_r, valid_nxt;
  rpip_pkg::rpip_result_t data_r, data_nxt;

  // full and not drained this cycle
  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = result;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid        = valid_r;
  assign out_parsed_value = data_r.value;
  assign out_parse_error  = data_r.error;

endmodule

### sv/radix_prefix_integer_parser_unit.sv
`timescale 1ns / 1ps
// a terminator is held in the input register, then its result loads the result register
// throughput: one byte per cycle when not stalled; the multiply-add is combinational
// a terminator waits in the input register while the result register is full and stalled
// reset (rst_n low, synchronous): both registers empty, accumulator 0, radix 10, sign
// positive, no error
// ----------------------------------------------------------------------------
// radix_prefix_integer_parser_unit
// Parses a byte stream into a signed 32-bit integer with optional radix prefix.
// ----------------------------------------------------------------------------
module radix_prefix_integer_parser_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rpip_pkg::CODE_W-1:0]         in_char_code,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rpip_pkg::VALUE_W-1:0] out_parsed_value,
  output logic                                out_parse_error
);

  logic                          hold_valid;
  logic [rpip_pkg::CODE_W-1:0]   hold_code;
  logic                          is_end;
  logic                          out_busy;
  logic                          take;
  rpip_pkg::rpip_result_t        result;

  // only a terminator needs room in the result register
  assign take = hold_valid && !(is_end && out_busy);

  rpip_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .take         (take),
    .hold_valid   (hold_valid),
    .hold_code    (hold_code)
  );

  rpip_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (take),
    .code   (hold_code),
    .is_end (is_end),
    .result (result)
  );

  rpip_out_reg u_out_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (take && is_end),
    .result           (result),
    .busy             (out_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_parsed_value (out_parsed_value),
    .out_parse_error  (out_parse_error)
  );

  // a stalled input always means a terminator is blocked by a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (hold_valid && is_end && out_valid && out_stall))
    else $error("input stalled without a blocked terminator");

  // a taken terminator always shows up as a result next cycle
  a_end_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_end) |=> out_valid)
    else $error("terminator taken but no result");

  // a non-terminator never raises a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !(take && is_end)) |=> !out_valid)
    else $error("result appeared without terminator");

endmodule

### bench/radix_prefix_integer_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_prefix_integer_parser_checker
// Watches both channels of the parser, tracks the parse state of the text
// stream itself and compares every result item with the value it expects.
// ----------------------------------------------------------------------------
module radix_prefix_integer_parser_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [rpip_pkg::CODE_W-1:0]         in_char_code,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [rpip_pkg::VALUE_W-1:0] out_parsed_value,
  input  logic                                out_parse_error,
  output int                                  mismatch_count,
  output int                                  pending_count,
  output int                                  checked_count,
  output int                                  flagged_count
);

  localparam int VAL_W = rpip_pkg::VALUE_W;

  logic [VAL_W-1:0]       acc_model;
  logic [VAL_W-1:0]       radix_model;
  logic                   minus_model;
  logic                   bad_model;
  rpip_pkg::rpip_result_t expected_results[$];
  rpip_pkg::rpip_result_t oldest;

  task automatic clear_parse();
    acc_model   = '0;
    radix_model = VAL_W'(rpip_pkg::RADIX_DEFAULT);
    minus_model = 1'b0;
    bad_model   = 1'b0;
  endtask

  // advance the parse by one text byte, queue a result on the terminator
  task automatic absorb_char(input logic [rpip_pkg::CODE_W-1:0] code);
    int                     x;
    rpip_pkg::rpip_result_t res;
    if (code == rpip_pkg::CODE_END) begin
      if (bad_model) begin
        res.value = rpip_pkg::VALUE_ERROR;
      end else begin
        res.value = minus_model ? (VAL_W'(0) - acc_model) : acc_model;
      end
      res.error = bad_model;
      expected_results.push_back(res);
      clear_parse();
    end else if (!bad_model) begin
      x = int'(code & rpip_pkg::CASE_MASK) - int'(rpip_pkg::MAP_OFFSET);
      if (x == int'(rpip_pkg::X_MINUS)) begin
        minus_model = !minus_model;
      end else if (x == int'(rpip_pkg::X_PREFIX)
                   && radix_model == VAL_W'(rpip_pkg::RADIX_DEFAULT)) begin
        radix_model = acc_model;
        acc_model   = '0;
        if (radix_model == '0) radix_model = VAL_W'(rpip_pkg::RADIX_ZERO);
        // unsigned compare, so a huge prefix is rejected too
        if (radix_model < rpip_pkg::RADIX_MIN || radix_model > rpip_pkg::RADIX_MAX)
          bad_model = 1'b1;
      end else begin
        if (x > int'(rpip_pkg::X_LETTER_MAX)) x = x - int'(rpip_pkg::LETTER_SHIFT);
        if (x >= int'(radix_model)) begin
          bad_model = 1'b1;
        end else begin
          // negative digits are added sign-extended
          acc_model = acc_model * radix_model + VAL_W'(x);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_results.delete();
      mismatch_count = 0;
      checked_count  = 0;
      flagged_count  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result item: value %0d error %0b",
                     $realtime, out_parsed_value, out_parse_error);
        end else begin
          oldest = expected_results.pop_front();
          checked_count++;
          if (oldest.error) flagged_count++;
          if (oldest.value !== out_parsed_value || oldest.error !== out_parse_error) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch: expected %0d err %0b, got %0d err %0b",
                       $realtime, oldest.value, oldest.error,
                       out_parsed_value, out_parse_error);
          end
        end
      end
      if (in_valid && !in_stall) absorb_char(in_char_code);
    end
    pending_count = expected_results.size();
  end

endmodule

### bench/radix_prefix_integer_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_prefix_integer_parser_unit_tb
// Feeds the parser a few hand-picked strings and then about a thousand
// random text bytes, mostly well-formed numbers with signs and radix
// prefixes, under bursty input and random output stalls.
// ----------------------------------------------------------------------------
module radix_prefix_integer_parser_unit_tb;

  localparam int CHR_W       = rpip_pkg::CODE_W;
  localparam int VAL_W       = rpip_pkg::VALUE_W;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int TEXT_TARGET = 1100;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CHR_W-1:0]         in_char_code;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VAL_W-1:0]  out_parsed_value;
  logic                     out_parse_error;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int flagged_count;

  int sent_chars;
  int sent_strings;
  int burst_left;
  int idle_cycles;
  int hold_done;

  logic [CHR_W-1:0] text_bytes[$];

  // empty string, signed hex, base 36 letters, radix too large, bad digit
  // followed by an ignored minus, negative digit then a high-bit bad digit
  logic [CHR_W-1:0] opening_text [23] = '{
    8'h00,
    8'h2D, 8'h30, 8'h78, 8'h31, 8'h46, 8'h00,
    8'h33, 8'h36, 8'h78, 8'h7A, 8'h5A, 8'h00,
    8'h33, 8'h37, 8'h58, 8'h00,
    8'hFF, 8'h0D, 8'h00,
    8'h20, 8'h8D, 8'h00
  };

  logic [CHR_W-1:0] minus_chars  [2] = '{8'h2D, 8'h0D};
  logic [CHR_W-1:0] prefix_chars [2] = '{8'h58, 8'h78};

  radix_prefix_integer_parser_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_parsed_value (out_parsed_value),
    .out_parse_error  (out_parse_error)
  );

  radix_prefix_integer_parser_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_parsed_value (out_parsed_value),
    .out_parse_error  (out_parse_error),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .flagged_count    (flagged_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // offer one text byte, opening a new burst after a random gap when due
  task automatic offer_char(input logic [CHR_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    sent_chars++;
    if (code == rpip_pkg::CODE_END) sent_strings++;
  endtask

  // one random string: mostly optional signs, an optional radix prefix and digits, else noise
  task automatic compose_number_text();
    int               kind;
    int               nsign;
    int               radix;
    int               ndig;
    int               d;
    int               sel;
    logic [VAL_W-1:0] rv;
    logic [CHR_W-1:0] digs[$];
    text_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // noise
      repeat ($urandom_range(1, 6)) text_bytes.push_back(CHR_W'($urandom_range(1, 255)));
    end else begin
      nsign = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (nsign) text_bytes.push_back(minus_chars[$urandom_range(0, 1)]);
      radix = 10;
      if ($urandom_range(0, 2) == 0) begin
        sel = $urandom_range(0, 19);
        case (sel)
          0: rv = '0;
          1: rv = ($urandom_range(0, 1) != 0) ? 32'd1 : VAL_W'($urandom_range(37, 99));
          2: rv = 32'd10;
          3: rv = 32'h8000_0000 + VAL_W'($urandom());
          default: rv = VAL_W'($urandom_range(2, 36));
        endcase
        if (rv >= rpip_pkg::RADIX_MIN && rv <= rpip_pkg::RADIX_MAX) radix = int'(rv);
        if (rv == '0) radix = 16;
        // a bare prefix also gives radix sixteen
        if (!(rv == '0 && $urandom_range(0, 1) != 0)) begin
          digs.delete();
          do begin
            digs.push_front(8'h30 + CHR_W'(rv % 10));
            rv = rv / 10;
          end while (rv != '0);
          text_bytes = {text_bytes, digs};
        end
        text_bytes.push_back(prefix_chars[$urandom_range(0, 1)]);
      end
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
      repeat (ndig) begin
        if ($urandom_range(0, 29) == 0) begin
          text_bytes.push_back(CHR_W'($urandom_range(1, 255)));
        end else begin
          d = $urandom_range(0, radix - 1);
          if (d < 10)
            text_bytes.push_back(8'h30 + CHR_W'(d));
          else if (d == 10 && $urandom_range(0, 1) != 0)
            text_bytes.push_back(8'h3A);
          else
            text_bytes.push_back((8'h41 + CHR_W'(d - 10)) |
                                 (($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00));
        end
      end
    end
    text_bytes.push_back(rpip_pkg::CODE_END);
  endtask

  // receiver: stall phases of random style, one long hold-off early on
  initial begin
    int mode;
    int phase;
    out_stall = 1'b0;
    hold_done = 0;
    phase     = 0;
    @(posedge rst_n);
    forever begin
      if (phase == 6 && hold_done == 0) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1;
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 40)) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) != 0);
          default: out_stall <= ($urandom_range(0, 4) != 0);
        endcase
      end
      phase++;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    sent_chars   = 0;
    sent_strings = 0;
    burst_left   = 0;
    idle_cycles  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_text[i]) offer_char(opening_text[i]);

    while (sent_chars < TEXT_TARGET) begin
      compose_number_text();
      foreach (text_bytes[i]) offer_char(text_bytes[i]);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d text bytes in %0d strings, %0d results checked, %0d with error",
             sent_chars, sent_strings, checked_count, flagged_count);
    $display("receiver held off %0d cycles once with the sender still offering", HOLD_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
